// ----- rtl/core/mle_pkg.sv -----
// Package for the margin loss evaluator: loss kind codes, register indexes,
// fixed-point constants, pipeline item and result types, saturation helper.
// No dependencies.
`default_nettype none

package mle_pkg;

  typedef enum logic [1:0] {
    KIND_SQ_HINGE = 2'd0,
    KIND_HUBER    = 2'd1,
    KIND_LOGISTIC = 2'd2
  } loss_kind_e;

  localparam logic REG_LOSS_KIND = 1'b0;
  localparam logic REG_HUBER_EPS = 1'b1;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_DATA_W    = 31;
  localparam logic [30:0] EPS_RESET = 31'd65536;

  // Divider geometry: 32-bit divisor, 32 quotient bits.
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 32;

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] EXP_C5    = 64'd1431680;
  localparam logic [63:0] ATANH_C7  = 64'd306783378;

  // Horner constants of the 2^-f polynomial, applied one per stage.
  localparam logic [63:0] HORNER_C [5] = '{
    64'd10327388, 64'd59597083, 64'd257941248, 64'd744261118, 64'd1073741824
  };
  // Constants of the atanh series for log1p, applied one per stage.
  localparam logic [63:0] ATANH_C [3] = '{
    64'd429496730, 64'd715827883, 64'd2147483648
  };

  typedef struct packed {
    logic signed [31:0] margin;
    logic signed [33:0] v;
    logic [31:0]        a;
    logic [63:0]        sqm;
    logic [62:0]        tlog;
    logic               vpos;
    logic               vgt;
    logic               kbig;
    logic [4:0]         ksh;
    logic [29:0]        f;
    logic [30:0]        p;
    logic [31:0]        e_lv;
    logic [31:0]        e_g;
    logic [31:0]        e_q;
    logic               e_flag;
    logic [31:0]        quo0;
    logic               ovf0;
    logic [31:0]        quo1;
    logic [31:0]        quo2;
    logic [30:0]        s;
    logic [30:0]        sc;
    logic [29:0]        z;
    logic [29:0]        z2;
    logic [30:0]        cur;
    logic [32:0]        t;
    logic [31:0]        lg;
  } item_t;

  typedef struct packed {
    logic [31:0] lv;
    logic [31:0] g;
    logic [31:0] q;
    logic        flag;
  } res_t;

  typedef struct packed {
    logic        flag;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    r.flag = 1'b0;
    r.val  = x[31:0];
    if (x > 64'sd2147483647) begin
      r.flag = 1'b1;
      r.val  = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r.flag = 1'b1;
      r.val  = 32'h8000_0000;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mle_div.sv -----
// Pipelined radix-2 restoring divider for the margin loss evaluator.
// One quotient bit per stage, with a flag for quotients that do not fit.
// No dependencies.
`default_nettype none

module mle_div #(
  parameter int DEN_W = 32,
  parameter int QUO_W = 32,
  localparam int NUM_W = DEN_W + QUO_W
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o,
  output logic                  ovf_o
);

  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] wrd_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  // The upper dividend half starts as the remainder; if it already reaches
  // the divisor the quotient needs more than QUO_W bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[NUM_W-1:QUO_W];
      wrd_q[0] <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
      ovf_q[0] <= (num_i[NUM_W-1:QUO_W] >= den_i);
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_q[i], wrd_q[i][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[i]};
    assign ge    = (trial >= {1'b0, den_q[i]});

    // Dividend bits leave the word at the top while quotient bits enter below.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        wrd_q[i+1] <= {wrd_q[i][QUO_W-2:0], ge};
        den_q[i+1] <= den_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  assign quo_o = wrd_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

`default_nettype wire

// ----- rtl/core/margin_loss_evaluator.sv -----
// Top level of the margin loss evaluator: pipeline, configuration registers
// and output skid stage. Depends on mle_pkg and mle_div.
`default_nettype none

// The block takes one signed fixed-point margin per cycle unless stalled and
// returns loss, derivative and curvature for squared hinge, Huber hinge or
// logistic loss, chosen by the loss_kind register; results that do not fit
// 32 bits are clipped and flagged. Without stalls it sustains one transfer per
// clock in both directions. Most of a margin's way to its result is the
// 32-step divider pipeline (Huber quotients, sigmoid and the log1p argument),
// plus exp and log1p polynomial stages with one multiplier each. A two-entry
// output stage keeps input acceptance going while one result waits;
// in_stall_o is a registered signal.
module margin_loss_evaluator #(
  parameter int FRAC_BITS = mle_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [mle_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [31:0]            margin_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [31:0]                 loss_value_o,
  output logic signed [31:0]                 first_derivative_o,
  output logic signed [31:0]                 second_derivative_o,
  output logic                               saturated_o
);

  localparam int ST_MUL   = 1;
  localparam int ST_EARLY = 2;
  localparam int ST_HORN0 = 3;
  localparam int HORN_N   = 5;
  localparam int ST_DIVIN = ST_HORN0 + HORN_N - 1;
  localparam int DIV_LAT  = mle_pkg::DIV_QW + 1;
  localparam int ST_QUO   = ST_DIVIN + DIV_LAT + 1;
  localparam int ST_SQ    = ST_QUO + 1;
  localparam int ST_ATN0  = ST_SQ + 1;
  localparam int ATN_N    = 3;
  localparam int ST_LOG   = ST_ATN0 + ATN_N;
  localparam int LAT      = ST_LOG + 1;
  localparam int SH       = 30 - FRAC_BITS;

  localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] SQ_ONE  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] Q60_ONE = 64'd1 << 60;

  mle_pkg::loss_kind_e kind_q;
  logic [30:0]         eps_q;
  logic [30:0]         eps_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= mle_pkg::KIND_SQ_HINGE;
      eps_q  <= mle_pkg::EPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mle_pkg::REG_LOSS_KIND: kind_q <= mle_pkg::loss_kind_e'(cfg_wdata_i[1:0]);
        mle_pkg::REG_HUBER_EPS: eps_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero width acts as one LSB.
  assign eps_eff = (eps_q == '0) ? 31'd1 : eps_q;

  // ---------------------------------------------------------------- pipeline
  logic               adv;
  logic               in_acc;
  logic [LAT-1:0]     vld_q;
  mle_pkg::item_t     st_q [LAT];
  mle_pkg::item_t     st_d [LAT];

  logic               skid_vld_q;
  logic               out_vld_q;
  mle_pkg::res_t      out_q;
  mle_pkg::res_t      skid_q;
  mle_pkg::res_t      res_d;

  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Entry stage: margin, v = ONE - margin and |margin|.
  always_comb begin
    logic [32:0] mneg;
    mneg       = -{margin_i[31], margin_i};
    st_d[0]    = '0;
    st_d[0].margin = margin_i;
    st_d[0].v  = $signed(34'(ONE)) - 34'(margin_i);
    st_d[0].a  = margin_i[31] ? mneg[31:0] : margin_i[31:0];
  end

  for (genvar g = 1; g < LAT; g++) begin : g_stage
    if (g == ST_MUL) begin : g_mul
      always_comb begin
        st_d[g]      = st_q[g-1];
        st_d[g].sqm  = 64'(st_q[g-1].v[31:0]) * 64'(st_q[g-1].v[31:0]);
        st_d[g].tlog = 63'(st_q[g-1].a) * 63'(mle_pkg::LOG2E_Q30);
      end
    end else if (g == ST_EARLY) begin : g_early
      always_comb begin
        logic [62:0]     kw;
        mle_pkg::sat_t   s_lv;
        mle_pkg::sat_t   s_g;
        mle_pkg::sat_t   s_q;
        st_d[g]      = st_q[g-1];
        kw           = st_q[g-1].tlog >> (FRAC_BITS + 30);
        st_d[g].vpos = !st_q[g-1].v[33] && (st_q[g-1].v != '0);
        st_d[g].vgt  = (st_q[g-1].v[31:0] > {1'b0, eps_eff});
        st_d[g].kbig = (kw > 63'd30);
        st_d[g].ksh  = kw[4:0];
        st_d[g].f    = st_q[g-1].tlog[FRAC_BITS +: 30];
        st_d[g].p    = 31'(mle_pkg::EXP_C5);
        s_lv = mle_pkg::sat32($signed(st_q[g-1].sqm >> FRAC_BITS));
        s_g  = mle_pkg::sat32(-(64'(st_q[g-1].v) <<< 1));
        s_q  = mle_pkg::sat32($signed(ONE << 1));
        st_d[g].e_lv   = '0;
        st_d[g].e_g    = '0;
        st_d[g].e_q    = '0;
        st_d[g].e_flag = 1'b0;
        case (kind_q)
          mle_pkg::KIND_SQ_HINGE: begin
            if (st_d[g].vpos) begin
              st_d[g].e_lv   = s_lv.val;
              st_d[g].e_g    = s_g.val;
              st_d[g].e_q    = s_q.val;
              st_d[g].e_flag = s_lv.flag | s_g.flag | s_q.flag;
            end
          end
          mle_pkg::KIND_HUBER: begin
            if (st_d[g].vpos && st_d[g].vgt) begin
              s_lv = mle_pkg::sat32(64'(st_q[g-1].v) - $signed(64'(eps_eff >> 1)));
              st_d[g].e_lv   = s_lv.val;
              st_d[g].e_g    = 32'(-ONE);
              st_d[g].e_flag = s_lv.flag;
            end
          end
          default: ;
        endcase
      end
    end else if (g >= ST_HORN0 && g <= ST_DIVIN) begin : g_horner
      always_comb begin
        logic [60:0] prod;
        st_d[g]   = st_q[g-1];
        prod      = 61'(st_q[g-1].f) * 61'(st_q[g-1].p);
        st_d[g].p = 31'(mle_pkg::HORNER_C[g-ST_HORN0]) - 31'(prod >> 30);
      end
    end else if (g == ST_QUO) begin : g_quo
      // Filled in by the divider outputs below.
    end else if (g == ST_SQ) begin : g_sq
      always_comb begin
        logic [59:0] zz;
        logic [61:0] ss;
        st_d[g]     = st_q[g-1];
        zz          = 60'(st_q[g-1].z) * 60'(st_q[g-1].z);
        ss          = 62'(st_q[g-1].s) * 62'(st_q[g-1].sc);
        st_d[g].z2  = 30'(zz >> 30);
        st_d[g].cur = 31'(ss >> 30);
        st_d[g].t   = 33'(mle_pkg::ATANH_C7);
      end
    end else if (g >= ST_ATN0 && g < ST_LOG) begin : g_atanh
      always_comb begin
        logic [62:0] prod;
        st_d[g]   = st_q[g-1];
        prod      = 63'(st_q[g-1].z2) * 63'(st_q[g-1].t);
        st_d[g].t = 33'(mle_pkg::ATANH_C[g-ST_ATN0]) + 33'(prod >> 30);
      end
    end else if (g == ST_LOG) begin : g_log
      always_comb begin
        logic [62:0] prod;
        st_d[g]    = st_q[g-1];
        prod       = 63'(st_q[g-1].z) * 63'(st_q[g-1].t);
        st_d[g].lg = 32'(prod >> 30);
      end
    end else begin : g_copy
      always_comb st_d[g] = st_q[g-1];
    end
  end

  // Divider operands from the last exp stage.
  logic [30:0] e_exp;
  logic [31:0] uv7;
  logic [63:0] n0, n1, n2;
  logic [31:0] d0, d1, d2;
  logic [31:0] quo0, quo1, quo2;
  logic        ovf0, ovf1, ovf2;

  always_comb begin
    e_exp = st_q[ST_DIVIN].kbig ? '0 : (st_q[ST_DIVIN].p >> st_q[ST_DIVIN].ksh);
    uv7   = st_q[ST_DIVIN].v[31:0];
    n0 = '0; n1 = '0; n2 = '0;
    d0 = 32'd1; d1 = 32'd1; d2 = 32'd1;
    case (kind_q)
      mle_pkg::KIND_HUBER: begin
        n0 = SQ_ONE;
        d0 = st_q[ST_DIVIN].vgt ? uv7 : {1'b0, eps_eff};
        n1 = st_q[ST_DIVIN].sqm;
        d1 = {eps_eff, 1'b0};
        n2 = 64'(uv7) << FRAC_BITS;
        d2 = {1'b0, eps_eff};
      end
      mle_pkg::KIND_LOGISTIC: begin
        n0 = Q60_ONE;
        d0 = 32'(mle_pkg::Q30_ONE) + 32'(e_exp);
        n1 = 64'(e_exp) << 30;
        d1 = 32'h8000_0000 + 32'(e_exp);
      end
      default: ;
    endcase
  end

  mle_div #(.DEN_W(mle_pkg::DIV_DW), .QUO_W(mle_pkg::DIV_QW)) u_div0 (
    .clk_i(clk_i), .en_i(adv), .num_i(n0), .den_i(d0), .quo_o(quo0), .ovf_o(ovf0)
  );
  mle_div #(.DEN_W(mle_pkg::DIV_DW), .QUO_W(mle_pkg::DIV_QW)) u_div1 (
    .clk_i(clk_i), .en_i(adv), .num_i(n1), .den_i(d1), .quo_o(quo1), .ovf_o(ovf1)
  );
  mle_div #(.DEN_W(mle_pkg::DIV_DW), .QUO_W(mle_pkg::DIV_QW)) u_div2 (
    .clk_i(clk_i), .en_i(adv), .num_i(n2), .den_i(d2), .quo_o(quo2), .ovf_o(ovf2)
  );

  always_comb begin
    st_d[ST_QUO]      = st_q[ST_QUO-1];
    st_d[ST_QUO].quo0 = quo0;
    st_d[ST_QUO].ovf0 = ovf0;
    // These two quotients are set to all ones when their divider flags an overflow.
    st_d[ST_QUO].quo1 = ovf1 ? '1 : quo1;
    st_d[ST_QUO].quo2 = ovf2 ? '1 : quo2;
    st_d[ST_QUO].s    = quo0[30:0];
    st_d[ST_QUO].sc   = 31'(mle_pkg::Q30_ONE) - quo0[30:0];
    st_d[ST_QUO].z    = quo1[29:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < LAT; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_acc};
    end
  end

  // ---------------------------------------------------------- result select
  always_comb begin
    mle_pkg::item_t it;
    mle_pkg::sat_t  sq;
    mle_pkg::sat_t  sl;
    logic [31:0]    lp;
    it    = st_q[LAT-1];
    res_d = '0;
    sq.flag = it.ovf0 | it.quo0[31];
    sq.val  = sq.flag ? 32'h7fff_ffff : it.quo0;
    lp = it.lg >> SH;
    sl = mle_pkg::sat32($signed(64'(it.a) + 64'(lp)));
    case (kind_q)
      mle_pkg::KIND_SQ_HINGE: begin
        res_d.lv   = it.e_lv;
        res_d.g    = it.e_g;
        res_d.q    = it.e_q;
        res_d.flag = it.e_flag;
      end
      mle_pkg::KIND_HUBER: begin
        if (it.vpos) begin
          res_d.q = sq.val;
          if (it.vgt) begin
            res_d.lv   = it.e_lv;
            res_d.g    = it.e_g;
            res_d.flag = it.e_flag | sq.flag;
          end else begin
            res_d.lv   = it.quo1;
            res_d.g    = -it.quo2;
            res_d.flag = sq.flag;
          end
        end
      end
      mle_pkg::KIND_LOGISTIC: begin
        res_d.q = 32'(it.cur >> SH);
        if (!it.margin[31]) begin
          res_d.lv = lp;
          res_d.g  = -32'(it.sc >> SH);
        end else begin
          res_d.lv   = sl.val;
          res_d.g    = -32'(it.s >> SH);
          res_d.flag = sl.flag;
        end
      end
      default: ;
    endcase
  end

  // Output register plus one skid entry that catches the item already in
  // flight when the consumer stalls.
  logic arrive;
  logic out_free;
  assign arrive   = adv && vld_q[LAT-1];
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= arrive;
      end
    end else if (arrive) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (arrive) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign loss_value_o        = out_q.lv;
  assign first_derivative_o  = out_q.g;
  assign second_derivative_o = out_q.q;
  assign saturated_o         = out_q.flag;

  // -------------------------------------------------------------- checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while output register empty");

  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valids moved while frozen");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> vld_q[0])
    else $error("accepted margin did not enter the pipeline");

  a_catch_in_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i && !skid_vld_q && vld_q[LAT-1]) |=> skid_vld_q)
    else $error("finished item not caught by skid entry");

endmodule

`default_nettype wire
